// ===== hdl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants, types and register codes of the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int VEC_WIDTH  = 24;
    localparam int FRAC_BITS  = 14;
    localparam int Q_W        = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = Q_W;

    // matrix entry: 2*(a*b - c*d) on Q_W-bit operands
    localparam int M_W = 2 * Q_W + 2;
    // one matrix-by-component product
    localparam int P_W = M_W + VEC_WIDTH;
    // row sum with rounding offset
    localparam int S_W = (P_W + 2 > 2 * FRAC_BITS + 2) ? P_W + 2 : 2 * FRAC_BITS + 2;
    // rounded row sum before saturation
    localparam int R_W = S_W - 2 * FRAC_BITS;

    localparam logic signed [Q_W-1:0] QUAT_ONE = Q_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W = CFG_IDX_W'(0),
        REG_QUAT_X = CFG_IDX_W'(1),
        REG_QUAT_Y = CFG_IDX_W'(2),
        REG_QUAT_Z = CFG_IDX_W'(3)
    } t_reg_idx;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] vec_x;
        logic signed [VEC_WIDTH-1:0] vec_y;
        logic signed [VEC_WIDTH-1:0] vec_z;
    } t_vec;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] rot_x;
        logic signed [VEC_WIDTH-1:0] rot_y;
        logic signed [VEC_WIDTH-1:0] rot_z;
        logic                        clipped;
    } t_rot;

    typedef logic signed [M_W-1:0] t_mat_elem;

    // row-major 3x3 rotation matrix, entry (i,j) at 3*i+j
    typedef t_mat_elem [8:0] t_mat;

endpackage

// ===== hdl/qvr_if.sv =====
// ----------------------------------------------------------------------------
// qvr_if
// Valid/ready channels for input vectors and rotated results.
// ----------------------------------------------------------------------------
interface qvr_vec_if;
    logic          valid;
    logic          ready;
    qvr_pkg::t_vec data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qvr_rot_if;
    logic          valid;
    logic          ready;
    qvr_pkg::t_rot data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/qvr_matrix.sv =====
// ----------------------------------------------------------------------------
// qvr_matrix
// Quaternion registers and the two-stage build of the integer rotation matrix.
// ----------------------------------------------------------------------------
module qvr_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output qvr_pkg::t_mat                       o_mat
);

    localparam int QW  = qvr_pkg::Q_W;
    localparam int MW  = qvr_pkg::M_W;
    localparam int PPW = 2 * QW;

    logic signed [QW-1:0]  r_qw, r_qx, r_qy, r_qz;
    logic signed [PPW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    qvr_pkg::t_mat         r_mat;
    qvr_pkg::t_mat         n_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw <= qvr_pkg::QUAT_ONE;
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qvr_pkg::REG_QUAT_W: begin
                    r_qw <= $signed(i_cfg_data[QW-1:0]);
                end
                qvr_pkg::REG_QUAT_X: begin
                    r_qx <= $signed(i_cfg_data[QW-1:0]);
                end
                qvr_pkg::REG_QUAT_Y: begin
                    r_qy <= $signed(i_cfg_data[QW-1:0]);
                end
                qvr_pkg::REG_QUAT_Z: begin
                    r_qz <= $signed(i_cfg_data[QW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ww <= r_qw * r_qw;
        r_xx <= r_qx * r_qx;
        r_yy <= r_qy * r_qy;
        r_zz <= r_qz * r_qz;
        r_xy <= r_qx * r_qy;
        r_xz <= r_qx * r_qz;
        r_yz <= r_qy * r_qz;
        r_wx <= r_qw * r_qx;
        r_wy <= r_qw * r_qy;
        r_wz <= r_qw * r_qz;
    end

    always_comb begin
        n_mat[0] = MW'(r_ww) + MW'(r_xx) - MW'(r_yy) - MW'(r_zz);
        n_mat[1] = (MW'(r_xy) - MW'(r_wz)) <<< 1;
        n_mat[2] = (MW'(r_xz) + MW'(r_wy)) <<< 1;
        n_mat[3] = (MW'(r_xy) + MW'(r_wz)) <<< 1;
        n_mat[4] = MW'(r_ww) - MW'(r_xx) + MW'(r_yy) - MW'(r_zz);
        n_mat[5] = (MW'(r_yz) - MW'(r_wx)) <<< 1;
        n_mat[6] = (MW'(r_xz) - MW'(r_wy)) <<< 1;
        n_mat[7] = (MW'(r_yz) + MW'(r_wx)) <<< 1;
        n_mat[8] = MW'(r_ww) - MW'(r_xx) - MW'(r_yy) + MW'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

// ===== hdl/qvr_datapath.sv =====
// ----------------------------------------------------------------------------
// qvr_datapath
// Five-stage vector pipeline: input, align, multiply, sum and round, saturate.
// ----------------------------------------------------------------------------
module qvr_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qvr_pkg::t_mat   i_mat,
    qvr_vec_if.sink         i_vec,
    qvr_rot_if.source       o_rot
);

    localparam int VW     = qvr_pkg::VEC_WIDTH;
    localparam int PW     = qvr_pkg::P_W;
    localparam int SW     = qvr_pkg::S_W;
    localparam int RW     = qvr_pkg::R_W;
    localparam int SH     = 2 * qvr_pkg::FRAC_BITS;
    localparam int STAGES = 5;

    localparam logic signed [SW-1:0] RND     = SW'(1) << (SH - 1);
    localparam logic signed [RW-1:0] OUT_MAX = (RW'(1) << (VW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] OUT_MIN = ~OUT_MAX;

    logic [STAGES-1:0]     r_vld;
    logic [STAGES-1:0]     adv;

    qvr_pkg::t_vec         r_v1, r_v2;
    logic signed [PW-1:0]  r_prod [9];
    logic signed [PW-1:0]  n_prod [9];
    logic signed [SW-1:0]  r_sum  [3];
    logic signed [SW-1:0]  n_sum  [3];
    qvr_pkg::t_rot         r_out;
    qvr_pkg::t_rot         n_out;

    logic signed [VW-1:0]  vc  [3];
    logic signed [RW-1:0]  res [3];
    logic signed [VW-1:0]  sat [3];
    logic [2:0]            clip;

    // per-stage advance, bubbles collapse
    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || o_rot.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_vec.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_vec.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        vc[0] = r_v2.vec_x;
        vc[1] = r_v2.vec_y;
        vc[2] = r_v2.vec_z;
        for (int k = 0; k < 9; k++) begin
            n_prod[k] = PW'($signed(i_mat[k])) * PW'(vc[k % 3]);
        end
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SW'(r_prod[3*i]) + SW'(r_prod[3*i+1]) + SW'(r_prod[3*i+2]) + RND;
        end
        for (int i = 0; i < 3; i++) begin
            res[i]  = $signed(r_sum[i][SW-1:SH]);
            clip[i] = 1'b0;
            sat[i]  = res[i][VW-1:0];
            if (res[i] > OUT_MAX) begin
                clip[i] = 1'b1;
                sat[i]  = OUT_MAX[VW-1:0];
            end else if (res[i] < OUT_MIN) begin
                clip[i] = 1'b1;
                sat[i]  = OUT_MIN[VW-1:0];
            end
        end
        n_out.rot_x   = sat[0];
        n_out.rot_y   = sat[1];
        n_out.rot_z   = sat[2];
        n_out.clipped = |clip;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_vec.valid) begin
            r_v1 <= i_vec.data;
        end
        if (adv[1] && r_vld[0]) begin
            r_v2 <= r_v1;
        end
        if (adv[2] && r_vld[1]) begin
            r_prod <= n_prod;
        end
        if (adv[3] && r_vld[2]) begin
            r_sum <= n_sum;
        end
        if (adv[4] && r_vld[3]) begin
            r_out <= n_out;
        end
    end

    assign o_rot.valid = r_vld[STAGES-1];
    assign o_rot.data  = r_out;

endmodule

// ===== hdl/quaternion_vector_rotate.sv =====
// Throughput 1 request/cycle while the result side does not apply back-pressure.
// Five register stages: input, vector align, matrix-by-vector multiply, row sum
// with rounding, saturate into the output register. The matrix is rebuilt from the
// quaternion in product and matrix registers, behind the first two vector stages.
// Reset (synchronous, active low): identity quaternion, pipeline empty.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a stream of 3-D integer vectors by a configured Q2.14 quaternion.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    qvr_vec_if.sink                             i_vec,
    qvr_rot_if.source                           o_rot
);

    qvr_pkg::t_mat mat;

    qvr_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mat      (mat)
    );

    qvr_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .i_vec   (i_vec),
        .o_rot   (o_rot)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams vectors through quaternion_vector_rotate under a series of rotation
// settings, with random gaps on the request side and random stalls on the
// result side, and checks every rotated result against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
    import qvr_pkg::*;

    localparam int VMAX          = 2 ** (VEC_WIDTH - 1) - 1;
    localparam int VMIN          = -(2 ** (VEC_WIDTH - 1));
    localparam int DRAIN_CYCLES  = 10;
    localparam int WATCHDOG      = 2000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 72;
    localparam int IDX_UNUSED_LO = REG_QUAT_Z + 1;
    localparam int IDX_UNUSED_HI = 2 ** CFG_IDX_W - 1;

    typedef struct packed {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } quat_t;

    class rotation_scoreboard;
        logic signed [Q_W-1:0] qw, qx, qy, qz;
        t_rot rot_due[$];
        int   errors;
        int   n_checked;
        int   n_clipped;

        function new();
            qw = QUAT_ONE;
            qx = '0;
            qy = '0;
            qz = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_QUAT_W: qw = val;
                REG_QUAT_X: qx = val;
                REG_QUAT_Y: qy = val;
                REG_QUAT_Z: qz = val;
                default: ;
            endcase
        endfunction

        // exact q*(0,v)*conj(q), rounded half up, saturated
        function t_rot rotate(t_vec v);
            longint w, x, y, z, acc;
            longint m[9];
            longint vv[3];
            t_rot   r;
            logic   clip;
            w = qw;
            x = qx;
            y = qy;
            z = qz;
            m[0] = w*w + x*x - y*y - z*z;
            m[1] = 2 * (x*y - w*z);
            m[2] = 2 * (x*z + w*y);
            m[3] = 2 * (x*y + w*z);
            m[4] = w*w - x*x + y*y - z*z;
            m[5] = 2 * (y*z - w*x);
            m[6] = 2 * (x*z - w*y);
            m[7] = 2 * (y*z + w*x);
            m[8] = w*w - x*x - y*y + z*z;
            vv[0] = longint'($signed(v.vec_x));
            vv[1] = longint'($signed(v.vec_y));
            vv[2] = longint'($signed(v.vec_z));
            clip = 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc = m[3*i] * vv[0] + m[3*i+1] * vv[1] + m[3*i+2] * vv[2];
                acc = (acc + (longint'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
                if (acc > VMAX) begin
                    acc  = VMAX;
                    clip = 1'b1;
                end
                if (acc < VMIN) begin
                    acc  = VMIN;
                    clip = 1'b1;
                end
                case (i)
                    0: r.rot_x = acc[VEC_WIDTH-1:0];
                    1: r.rot_y = acc[VEC_WIDTH-1:0];
                    default: r.rot_z = acc[VEC_WIDTH-1:0];
                endcase
            end
            r.clipped = clip;
            return r;
        endfunction

        function void note_vec(t_vec v);
            rot_due.push_back(rotate(v));
        endfunction

        function void check_rot(t_rot got);
            t_rot want;
            if (rot_due.size() == 0) begin
                $error("result with no pending request: x=%0d y=%0d z=%0d",
                       $signed(got.rot_x), $signed(got.rot_y), $signed(got.rot_z));
                errors++;
                return;
            end
            want = rot_due.pop_front();
            n_checked++;
            if (want.clipped)
                n_clipped++;
            if (got.rot_x !== want.rot_x) begin
                $error("rot_x: expected %0d, got %0d", $signed(want.rot_x), $signed(got.rot_x));
                errors++;
            end
            if (got.rot_y !== want.rot_y) begin
                $error("rot_y: expected %0d, got %0d", $signed(want.rot_y), $signed(got.rot_y));
                errors++;
            end
            if (got.rot_z !== want.rot_z) begin
                $error("rot_z: expected %0d, got %0d", $signed(want.rot_z), $signed(got.rot_z));
                errors++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction

        function int pending();
            return rot_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qvr_vec_if vec_ch ();
    qvr_rot_if rot_ch ();

    quaternion_vector_rotate u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vec      (vec_ch),
        .o_rot      (rot_ch)
    );

    rotation_scoreboard sb = new();

    logic bursty       = 1'b1;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   n_sent       = 0;
    int   n_settings   = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rot_ch.ready <= 1'b0;
        end else if (bursty && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 3);
            rot_ch.ready <= 1'b0;
        end else begin
            rot_ch.ready <= 1'b1;
        end
    end

    // monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && vec_ch.valid && vec_ch.ready)
            sb.note_vec(vec_ch.data);
        if (i_rst_n && rot_ch.valid && rot_ch.ready)
            sb.check_rot(rot_ch.data);
        if ((vec_ch.valid && vec_ch.ready) || (rot_ch.valid && rot_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no request or result for %0d cycles", WATCHDOG);
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic t_vec mk(int x, int y, int z);
        t_vec v;
        v.vec_x = x[VEC_WIDTH-1:0];
        v.vec_y = y[VEC_WIDTH-1:0];
        v.vec_z = z[VEC_WIDTH-1:0];
        return v;
    endfunction

    function automatic int rand_comp(int kind);
        int corner[5] = '{VMAX, VMIN, 0, -1, 1};
        if (kind <= 5)
            return int'($signed(VEC_WIDTH'($urandom)));
        if (kind <= 7)
            return int'($urandom_range(0, 2000)) - 1000;
        return corner[$urandom_range(0, 4)];
    endfunction

    function automatic t_vec rand_vec();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 9)
            return mk(rand_comp($urandom_range(0, 9)), rand_comp($urandom_range(0, 9)),
                      rand_comp($urandom_range(0, 9)));
        return mk(rand_comp(kind), rand_comp(kind), rand_comp(kind));
    endfunction

    function automatic quat_t rand_quat(int kind);
        real   a[4];
        real   n;
        quat_t q;
        int    axis;
        logic signed [Q_W-1:0] h;
        case (kind)
            0: begin
                do begin
                    for (int i = 0; i < 4; i++)
                        a[i] = real'($urandom_range(0, 65534)) / 32767.0 - 1.0;
                    n = $sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
                end while (n < 0.1);
                q.w = Q_W'($rtoi(a[0] * 16384.0 / n));
                q.x = Q_W'($rtoi(a[1] * 16384.0 / n));
                q.y = Q_W'($rtoi(a[2] * 16384.0 / n));
                q.z = Q_W'($rtoi(a[3] * 16384.0 / n));
            end
            1: q = {$urandom, $urandom};
            2: begin
                h    = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
                axis = $urandom_range(0, 2);
                q.w  = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
                q.x  = (axis == 0) ? h : '0;
                q.y  = (axis == 1) ? h : '0;
                q.z  = (axis == 2) ? h : '0;
            end
            default: begin
                q.w = Q_W'(int'($urandom_range(0, 16384)) - 8192);
                q.x = Q_W'(int'($urandom_range(0, 16384)) - 8192);
                q.y = Q_W'(int'($urandom_range(0, 16384)) - 8192);
                q.z = Q_W'(int'($urandom_range(0, 16384)) - 8192);
            end
        endcase
        return q;
    endfunction

    task automatic send_vec(t_vec v);
        if (bursty && $urandom_range(0, 3) == 0) begin
            vec_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.data  <= v;
        n_sent++;
        do @(posedge i_clk); while (!vec_ch.ready);
    endtask

    task automatic drain();
        vec_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_quat(quat_t q, bit stray);
        drain();
        cfg_write(REG_QUAT_W, q.w);
        cfg_write(REG_QUAT_X, q.x);
        if (stray)
            cfg_write(CFG_IDX_W'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI)),
                      CFG_DATA_W'($urandom));
        cfg_write(REG_QUAT_Y, q.y);
        cfg_write(REG_QUAT_Z, q.z);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        vec_ch.valid = 1'b0;
        vec_ch.data  = '0;
        rot_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset
        send_vec(mk(0, 0, 0));
        send_vec(mk(VMAX, VMAX, VMAX));
        send_vec(mk(VMIN, VMIN, VMIN));
        send_vec(mk(1, -1, 0));
        send_vec(mk(VMAX, VMIN, -1));

        // half-scale quaternion, quarter-scale result: exercises rounding ties in both signs
        set_quat('{w: 16'sd8192, x: '0, y: '0, z: '0}, 1'b0);
        send_vec(mk(2, -2, 6));
        send_vec(mk(-6, 1, -1));
        send_vec(mk(VMAX, VMIN, 3));

        // largest positive components, saturating
        set_quat('{w: 16'sh7fff, x: 16'sh7fff, y: 16'sh7fff, z: 16'sh7fff}, 1'b0);
        send_vec(mk(VMAX, VMAX, VMAX));
        send_vec(mk(VMIN, VMIN, VMIN));
        send_vec(mk(1, 0, 0));
        send_vec(mk(0, -1, 1));

        set_quat('{w: 16'sh8000, x: 16'sh8000, y: 16'sh8000, z: 16'sh8000}, 1'b0);
        send_vec(mk(VMAX, VMIN, VMAX));
        send_vec(mk(0, 0, 0));
        send_vec(mk(-1, -1, -1));

        // half turn about x negates y and z; most negative value overflows
        set_quat('{w: '0, x: 16'sd16384, y: '0, z: '0}, 1'b1);
        send_vec(mk(VMAX, VMAX, VMIN));
        send_vec(mk(VMIN, VMIN, VMAX));
        send_vec(mk(5, -7, 9));

        set_quat('{w: '0, x: '0, y: '0, z: '0}, 1'b1);
        send_vec(mk(VMAX, VMAX, VMAX));
        send_vec(mk(VMIN, 1, -1));

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_quat(rand_quat(p % 4), $urandom_range(0, 1));
            bursty = (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_vec(rand_vec());
        end

        drain();
        $display("sent %0d vectors under %0d quaternion settings", n_sent, n_settings);
        $display("checked %0d results, %0d of them saturated", sb.n_checked, sb.n_clipped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/qvr_pkg.sv
hdl/qvr_if.sv
hdl/qvr_matrix.sv
hdl/qvr_datapath.sv
hdl/quaternion_vector_rotate.sv
tb/sv/testbench.sv
